>>> design/sliding_window_mean_macros.svh
// Assertion macros shared by the sliding window mean design.
`ifndef SLIDING_WINDOW_MEAN_MACROS_SVH
`define SLIDING_WINDOW_MEAN_MACROS_SVH

`ifndef SYNTHESIS

`define SWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SWM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SWM_ASSERT(lbl, clk, rst_n, prop, msg)

`define SWM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> design/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int WINDOW_DEF = 16;
    localparam int SAMPLE_W   = 16;
    localparam int FILLED_W   = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_START,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

>>> design/swm_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module swm_ring
    import swm_pkg::*;
#(
    parameter int DEPTH = WINDOW_DEF,
    parameter int PTR_W = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rd_en,
    input  wire logic [PTR_W-1:0]           i_rd_addr,
    output logic signed [SAMPLE_W-1:0]      o_rd_data,
    input  wire logic                       i_wr_en,
    input  wire logic [PTR_W-1:0]           i_wr_addr,
    input  wire logic signed [SAMPLE_W-1:0] i_wr_data
);

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/swm_div.sv
`timescale 1ns / 1ps
`default_nettype none

module swm_div
    import swm_pkg::*;
#(
    parameter int SUM_W = 20,
    parameter int CNT_W = 5
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0]        i_divisor,
    output logic                         o_done,
    output logic signed [SAMPLE_W-1:0]   o_quotient
);

    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    logic              r_busy;
    logic              n_busy;
    logic              r_done;
    logic              n_done;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [SUM_W-1:0]  r_quo;
    logic              r_neg;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_fit;
    logic [SAMPLE_W-1:0] w_mag;

    // One restoring step per cycle: shift the next dividend bit into the remainder.
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
        end else if (r_busy) begin
            if (r_step == STEP_W'(SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_quo <= i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_fit};
        end
    end

    // The mean of the samples always fits the sample range, so the low bits suffice.
    assign w_mag      = r_quo[SAMPLE_W-1:0];
    assign o_quotient = r_neg ? (~w_mag + SAMPLE_W'(1)) : w_mag;
    assign o_done     = r_done;

endmodule

`default_nettype wire

>>> design/sliding_window_mean.sv
// Channel  | Valid    | Stall    | Payload
// ---------+----------+----------+------------------
// input    | i_valid  | o_stall  | i_sample
// output   | o_valid  | i_stall  | o_mean, o_filled
//
// A result is loaded after its transaction passes the accumulate, start and divide
// states, and waits in the done state while the output is stalled; the next
// transaction is accepted only after that. The restoring divider, one quotient bit
// a cycle, paces the divide state. The input is stalled until the result is loaded.
// A new transaction is accepted while the previous result still waits.
// Reset is synchronous and active low; the sample ring holds no reset value.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_mean_macros.svh"

module sliding_window_mean
    import swm_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [SAMPLE_W-1:0]      o_mean,
    output logic [FILLED_W-1:0]             o_filled
);

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    t_state                     r_state;
    t_state                     n_state;
    logic                       w_accept;
    logic                       w_div_start;
    logic                       w_div_done;
    logic                       w_load_out;
    logic                       w_full;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] w_rd_data;
    logic signed [SAMPLE_W-1:0] w_quotient;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SUM_W-1:0]    w_sub;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic [PTR_W-1:0]           r_wpos;
    logic [PTR_W-1:0]           n_wpos;
    logic                       r_out_valid;

    swm_ring #(
        .DEPTH (WINDOW),
        .PTR_W (PTR_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_wpos),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_state == ST_ACCUM),
        .i_wr_addr (r_wpos),
        .i_wr_data (r_sample)
    );

    swm_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        o_stall     = (r_state != ST_IDLE);
        w_accept    = (r_state == ST_IDLE) && i_valid;
        w_div_start = (r_state == ST_START);
        w_load_out  = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                n_state = ST_START;
            end
            ST_START: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Once the window is full, the overwritten sample leaves the running sum.
    assign w_full = (r_count == CNT_W'(WINDOW));
    assign w_sub  = w_full ? SUM_W'(w_rd_data) : SUM_W'(0);

    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        n_wpos  = r_wpos;
        if (r_state == ST_ACCUM) begin
            n_sum = r_sum + SUM_W'(r_sample) - w_sub;
            if (!w_full) begin
                n_count = r_count + CNT_W'(1);
            end
            if (r_wpos == PTR_W'(WINDOW - 1)) begin
                n_wpos = '0;
            end else begin
                n_wpos = r_wpos + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_wpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_wpos  <= n_wpos;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample;
        end
        if (w_load_out) begin
            o_mean   <= w_quotient;
            o_filled <= FILLED_W'(r_count);
        end
    end

    assign o_valid = r_out_valid;

    `SWM_ASSERT(a_stall_after_accept, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall, "input not stalled after a transaction was accepted")
    `SWM_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(o_valid) |-> $past(r_state == ST_DONE), "result presented without a finished division")
    `SWM_ASSERT(a_done_in_div, i_clk, i_rst_n, w_div_done |-> (r_state == ST_DIV), "divider finished outside the divide state")
    `SWM_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(WINDOW), "fill count exceeds the window")
    `SWM_ASSERT(a_count_nonzero, i_clk, i_rst_n, w_div_start |-> (r_count != '0), "division started with a zero fill count")

endmodule

`default_nettype wire
